### hw/rtl/ac4f_pkg.sv
// ----------------------------------------------------------------------------
// ac4f_pkg
// Shared types, constants and the CRC-16 step for the sync frame framer.
// ----------------------------------------------------------------------------
`default_nettype none

package ac4f_pkg;

  localparam logic [15:0] SYNC_PLAIN  = 16'hAC40;
  localparam logic [15:0] SYNC_CRC    = 16'hAC41;
  localparam logic [15:0] SIZE_ESCAPE = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h8005;

  localparam int unsigned MAX_RESULTS = 10;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    HDR_NONE,
    HDR_SHORT,
    HDR_LONG
  } hdr_kind_t;

  // All output words caused by one input word, first word in slot 0.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [CNT_W-1:0]            cnt;
    logic                        fend;
  } burst_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ac4f_in_if.sv
// ----------------------------------------------------------------------------
// ac4f_in_if
// Payload input channel: one data byte plus the frame size.
// ----------------------------------------------------------------------------
`default_nettype none

interface ac4f_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [23:0] frame_size;

  modport source (output valid, output data_byte, output frame_size, input ready);
  modport sink   (input valid, input data_byte, input frame_size, output ready);
endinterface

`default_nettype wire

### hw/rtl/ac4f_out_if.sv
// ----------------------------------------------------------------------------
// ac4f_out_if
// Framed output channel: one stream byte with frame and run markers.
// ----------------------------------------------------------------------------
`default_nettype none

interface ac4f_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       run_last;

  modport source (output valid, output out_byte, output frame_end, output run_last,
                  input ready);
  modport sink   (input valid, input out_byte, input frame_end, input run_last,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/ac4f_head.sv
// ----------------------------------------------------------------------------
// ac4f_head
// Frame tracking, CRC-16 and header build; registers one burst per word.
// ----------------------------------------------------------------------------
`default_nettype none

module ac4f_head (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic             cfg_wr_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_data,
  input  wire logic [23:0]      in_size,
  output logic                  pend_valid,
  output ac4f_pkg::burst_t      pend_burst,
  input  wire logic             pend_take
);

  logic                crc_enable_r;
  logic [23:0]         bytes_left_r;
  logic [15:0]         crc_r;
  logic                latched_r;
  logic                pend_valid_r;
  ac4f_pkg::burst_t    pend_r;

  logic                start;
  logic [23:0]         size;
  logic                latched;
  logic [15:0]         crc_base;
  logic [15:0]         crc_nxt;
  logic [23:0]         bl;
  logic [23:0]         bytes_left_nxt;
  logic                last;
  logic                tail;
  logic [15:0]         sync;
  ac4f_pkg::hdr_kind_t hdr;
  ac4f_pkg::burst_t    burst_nxt;
  logic                accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = !pend_valid_r || pend_take;

  assign start    = (bytes_left_r == 24'd0);
  assign size     = (in_size == 24'd0) ? 24'd1 : in_size;
  assign latched  = start ? crc_enable_r : latched_r;
  assign crc_base = start ? 16'h0000 : crc_r;
  assign crc_nxt  = latched ? ac4f_pkg::crc_update(crc_base, in_data) : crc_base;
  assign bl       = start ? size : bytes_left_r;
  assign bytes_left_nxt = bl - 24'd1;
  assign last     = (bytes_left_nxt == 24'd0);
  assign tail     = last && latched;
  assign sync     = latched ? ac4f_pkg::SYNC_CRC : ac4f_pkg::SYNC_PLAIN;

  always_comb begin
    if (!start) begin
      hdr = ac4f_pkg::HDR_NONE;
    end else if (size[23:16] != 8'h00) begin
      hdr = ac4f_pkg::HDR_LONG;
    end else begin
      hdr = ac4f_pkg::HDR_SHORT;
    end
  end

  always_comb begin
    burst_nxt       = '0;
    burst_nxt.fend  = last;
    case (hdr)
      ac4f_pkg::HDR_NONE: begin
        burst_nxt.bytes[0] = in_data;
        burst_nxt.bytes[1] = crc_nxt[15:8];
        burst_nxt.bytes[2] = crc_nxt[7:0];
        burst_nxt.cnt      = tail ? ac4f_pkg::CNT_W'(3) : ac4f_pkg::CNT_W'(1);
      end
      ac4f_pkg::HDR_SHORT: begin
        burst_nxt.bytes[0] = sync[15:8];
        burst_nxt.bytes[1] = sync[7:0];
        burst_nxt.bytes[2] = size[15:8];
        burst_nxt.bytes[3] = size[7:0];
        burst_nxt.bytes[4] = in_data;
        burst_nxt.bytes[5] = crc_nxt[15:8];
        burst_nxt.bytes[6] = crc_nxt[7:0];
        burst_nxt.cnt      = tail ? ac4f_pkg::CNT_W'(7) : ac4f_pkg::CNT_W'(5);
      end
      ac4f_pkg::HDR_LONG: begin
        burst_nxt.bytes[0] = sync[15:8];
        burst_nxt.bytes[1] = sync[7:0];
        burst_nxt.bytes[2] = ac4f_pkg::SIZE_ESCAPE[15:8];
        burst_nxt.bytes[3] = ac4f_pkg::SIZE_ESCAPE[7:0];
        burst_nxt.bytes[4] = size[23:16];
        burst_nxt.bytes[5] = size[15:8];
        burst_nxt.bytes[6] = size[7:0];
        burst_nxt.bytes[7] = in_data;
        burst_nxt.bytes[8] = crc_nxt[15:8];
        burst_nxt.bytes[9] = crc_nxt[7:0];
        burst_nxt.cnt      = tail ? ac4f_pkg::CNT_W'(10) : ac4f_pkg::CNT_W'(8);
      end
      default: begin
        burst_nxt.cnt = ac4f_pkg::CNT_W'(1);
        burst_nxt.bytes[0] = in_data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_enable_r <= 1'b0;
      bytes_left_r <= 24'd0;
      crc_r        <= 16'h0000;
      latched_r    <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        crc_enable_r <= cfg_wr_data;
      end
      if (accept) begin
        bytes_left_r <= bytes_left_nxt;
        crc_r        <= crc_nxt;
        latched_r    <= latched;
        pend_valid_r <= 1'b1;
      end else if (pend_take) begin
        pend_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_r <= burst_nxt;
    end
  end

  assign pend_valid = pend_valid_r;
  assign pend_burst = pend_r;

endmodule

`default_nettype wire

### hw/rtl/ac4f_emit.sv
// ----------------------------------------------------------------------------
// ac4f_emit
// Output register: shifts one burst out a word at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module ac4f_emit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             pend_valid,
  input  wire ac4f_pkg::burst_t pend_burst,
  output logic                  pend_take,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_frame_end,
  output logic                  out_run_last
);

  logic                              cur_valid_r;
  logic [ac4f_pkg::CNT_W-1:0]        rem_r;
  logic [ac4f_pkg::MAX_RESULTS-1:0][7:0] bytes_r;
  logic                              fend_r;

  logic                              fire;
  logic                              at_last;
  logic                              free;

  assign at_last   = (rem_r == ac4f_pkg::CNT_W'(1));
  assign fire      = cur_valid_r && out_ready;
  assign free      = !cur_valid_r || (out_ready && at_last);
  assign pend_take = pend_valid && free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      rem_r       <= '0;
    end else begin
      if (pend_take) begin
        cur_valid_r <= 1'b1;
        rem_r       <= pend_burst.cnt;
      end else if (fire) begin
        if (at_last) begin
          cur_valid_r <= 1'b0;
        end
        rem_r <= rem_r - ac4f_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_take) begin
      bytes_r <= pend_burst.bytes;
      fend_r  <= pend_burst.fend;
    end else if (fire) begin
      bytes_r <= bytes_r >> 8;
    end
  end

  assign out_valid     = cur_valid_r;
  assign out_byte      = bytes_r[0];
  assign out_run_last  = at_last;
  assign out_frame_end = at_last && fend_r;

endmodule

`default_nettype wire

### hw/rtl/ac4_sync_frame_framer.sv
// ----------------------------------------------------------------------------
// ac4_sync_frame_framer
// Wraps payload bytes as sync frames with size header and optional CRC-16.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_chan   in   valid/ready        data_byte[7:0], frame_size[23:0]
//  out_chan  out  valid/ready        out_byte[7:0], frame_end, run_last
//  cfg       in   cfg_wr_en          cfg_wr_data (crc_enable)
//
//  An input word yields 1 to 10 output words, sent one per cycle while
//  out_ready is high; the output shift register sets the rate, so mid-frame
//  words flow at one per cycle unless the output stalls. An accepted word is
//  registered in the burst buffer, then moved into the output shift register.
//  A burst buffer lets the next input word in while the output stalls.
//  Reset is synchronous and clears frame state and crc_enable.
// ----------------------------------------------------------------------------
`default_nettype none

module ac4_sync_frame_framer (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    cfg_wr_en,
  input  wire logic    cfg_wr_data,
  ac4f_in_if.sink      in_chan,
  ac4f_out_if.source   out_chan
);

  logic             pend_valid;
  ac4f_pkg::burst_t pend_burst;
  logic             pend_take;

  ac4f_head u_head (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .in_data     (in_chan.data_byte),
    .in_size     (in_chan.frame_size),
    .pend_valid  (pend_valid),
    .pend_burst  (pend_burst),
    .pend_take   (pend_take)
  );

  ac4f_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .pend_valid    (pend_valid),
    .pend_burst    (pend_burst),
    .pend_take     (pend_take),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .out_byte      (out_chan.out_byte),
    .out_frame_end (out_chan.frame_end),
    .out_run_last  (out_chan.run_last)
  );

  a_burst_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid |-> (pend_burst.cnt != '0 &&
                    pend_burst.cnt <= ac4f_pkg::CNT_W'(ac4f_pkg::MAX_RESULTS)))
    else $error("burst count out of range");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.frame_end) |-> out_chan.run_last)
    else $error("frame_end without run_last");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (pend_valid && !pend_take))
    else $error("input stalled with free buffer");

  a_take_moves: assert property (@(posedge clk) disable iff (!rst_n)
    pend_take |=> out_chan.valid)
    else $error("taken burst not presented");

endmodule

`default_nettype wire
